/* rtl/mersenne_twister_generator_core_macros.svh */
// Assertion macros for the MT19937 generator core.
// Taken in by the top level; expects clk and rst_n in scope.
`ifndef MERSENNE_TWISTER_GENERATOR_CORE_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MTG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mtg_pkg.sv */
// Shared constants and types for the MT19937 generator core.
// No dependencies.
`default_nettype none

package mtg_pkg;

    localparam int MTG_DEPTH_N = 624;
    localparam int MTG_IDX_W   = 10;

    localparam logic [MTG_IDX_W-1:0] MTG_DEPTH    = 10'd624;
    localparam logic [MTG_IDX_W-1:0] MTG_LAST     = 10'd623;
    localparam logic [MTG_IDX_W-1:0] MTG_UNSEEDED = 10'd625;
    localparam logic [MTG_IDX_W-1:0] MTG_OFFSET   = 10'd397;

    localparam logic [31:0] MTG_MATRIX   = 32'h9908_b0df;
    localparam logic [31:0] MTG_HIGH_BIT = 32'h8000_0000;
    localparam logic [31:0] MTG_LOW_BITS = 32'h7fff_ffff;
    localparam logic [31:0] MTG_TEMPER_B = 32'h9d2c_5680;
    localparam logic [31:0] MTG_TEMPER_C = 32'hefc6_0000;
    localparam logic [31:0] MTG_SEED_MUL = 32'd1812433253;
    localparam logic [31:0] MTG_DEF_SEED = 32'd5489;

    localparam logic OP_RESEED   = 1'b0;
    localparam logic OP_GENERATE = 1'b1;

    // One write into the state store.
    typedef struct packed {
        logic                 en;
        logic [MTG_IDX_W-1:0] addr;
        logic [31:0]          data;
    } mtg_wr_t;

    // Seeder status towards the sequencer.
    typedef struct packed {
        logic busy;
        logic last;
    } mtg_seed_stat_t;

endpackage

`default_nettype wire

/* rtl/mersenne_twister_generator_core.sv */
// MT19937 generator top level: state store, twist sequencer and handshakes.
// Depends on mtg_pkg, mtg_seed_unit, mtg_out_stage and the assertion macros.
// Generate beat with a ready word: store read registered, then tempered into the
//   output register; one word per cycle while the output is taken and no twist runs.
// Twist on the first generate after a seed, then every 624th.
// Reseed beat: paced by the registered multiply and the add per store word.
// First generate after reset: default seed plus twist.
// Reset clears control only; the store is unseeded until a reseed or first generate.
`default_nettype none

module mersenne_twister_generator_core
    import mtg_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           operation,
    input  wire logic [31:0]    seed,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [31:0]         value
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_TW_PRIME,
        ST_TWIST,
        ST_TW_LAST,
        ST_GEN
    } state_t;

    state_t               state_reg, state_next;
    logic [MTG_IDX_W-1:0] index_reg, index_next;
    logic                 gen_after_reg, gen_after_next;
    logic [MTG_IDX_W-1:0] ik_reg, ik_next;      // twist read index
    logic [MTG_IDX_W-1:0] wk_reg, wk_next;      // twist write index
    logic                 wv_reg, wv_next;      // twist write pending
    logic                 pend_reg, pend_next;  // store read in flight to output
    logic [31:0]          cur_reg;              // old store word k

    // state store, one write port, two read ports, read-first
    logic [31:0]          mem [MTG_DEPTH_N];
    logic                 mem_we;
    logic [MTG_IDX_W-1:0] mem_wa;
    logic [31:0]          mem_wd;
    logic                 re_a, re_b;
    logic [MTG_IDX_W-1:0] ra, rb;
    logic [31:0]          rd_a, rd_b;

    logic                 accept;
    logic                 blocked;
    logic                 seed_start;
    logic [31:0]          seed_word;
    mtg_wr_t              seed_wr;
    mtg_seed_stat_t       seed_stat;

    logic [MTG_IDX_W-1:0] nxt_idx, far_sum, far_idx;
    logic [31:0]          tw_y, tw_word;

    // ------------------------------------------------------------------
    // Twist arithmetic: neighbour index, far index and the new word
    // ------------------------------------------------------------------
    assign nxt_idx = (ik_reg == MTG_LAST) ? '0 : ik_reg + 1'b1;
    assign far_sum = ik_reg + MTG_OFFSET;
    assign far_idx = (far_sum >= MTG_DEPTH) ? far_sum - MTG_DEPTH : far_sum;

    assign tw_y    = (cur_reg & MTG_HIGH_BIT) | (rd_a & MTG_LOW_BITS);
    assign tw_word = rd_b ^ (tw_y >> 1) ^ (tw_y[0] ? MTG_MATRIX : 32'd0);

    // ------------------------------------------------------------------
    // Handshake: take a beat only when idle and any pending word can drain
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != ST_IDLE) || (pend_reg && blocked);
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        index_next     = index_reg;
        gen_after_next = gen_after_reg;
        ik_next        = ik_reg;
        wk_next        = wk_reg;
        wv_next        = 1'b0;
        pend_next      = pend_reg && blocked;
        seed_start     = 1'b0;
        seed_word      = seed;
        re_a           = 1'b0;
        re_b           = 1'b0;
        ra             = index_reg;
        rb             = far_idx;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_RESEED)
                    begin
                        seed_start     = 1'b1;
                        gen_after_next = 1'b0;
                        state_next     = ST_SEED;
                    end
                    else if (index_reg < MTG_DEPTH)
                    begin
                        // plain read of the next stored word
                        re_a       = 1'b1;
                        pend_next  = 1'b1;
                        index_next = index_reg + 1'b1;
                    end
                    else if (index_reg == MTG_UNSEEDED)
                    begin
                        seed_start     = 1'b1;
                        seed_word      = MTG_DEF_SEED;
                        gen_after_next = 1'b1;
                        state_next     = ST_SEED;
                    end
                    else
                    begin
                        state_next = ST_TW_PRIME;
                    end
                end
            end
            ST_SEED:
            begin
                if (seed_stat.last)
                begin
                    index_next = MTG_DEPTH;
                    state_next = gen_after_reg ? ST_TW_PRIME : ST_IDLE;
                end
            end
            ST_TW_PRIME:
            begin
                // fetch word 0 so the first step has its own old value
                re_a       = 1'b1;
                ra         = '0;
                ik_next    = '0;
                state_next = ST_TWIST;
            end
            ST_TWIST:
            begin
                re_a    = 1'b1;
                re_b    = 1'b1;
                ra      = nxt_idx;
                wv_next = 1'b1;
                wk_next = ik_reg;
                if (ik_reg == MTG_LAST)
                    state_next = ST_TW_LAST;
                else
                    ik_next = ik_reg + 1'b1;
            end
            ST_TW_LAST:
            begin
                index_next = '0;
                state_next = ST_GEN;
            end
            ST_GEN:
            begin
                re_a       = 1'b1;
                pend_next  = 1'b1;
                index_next = index_reg + 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            index_reg     <= MTG_UNSEEDED;
            gen_after_reg <= 1'b0;
            ik_reg        <= '0;
            wk_reg        <= '0;
            wv_reg        <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            index_reg     <= index_next;
            gen_after_reg <= gen_after_next;
            ik_reg        <= ik_next;
            wk_reg        <= wk_next;
            wv_reg        <= wv_next;
            pend_reg      <= pend_next;
        end
    end

    // hold the old word k for the step after its read lands
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TWIST || state_reg == ST_TW_LAST)
            cur_reg <= rd_a;
    end

    // ------------------------------------------------------------------
    // Store write arbitration: seeder and twist never overlap
    // ------------------------------------------------------------------
    assign mem_we = seed_wr.en || wv_reg;
    assign mem_wa = seed_wr.en ? seed_wr.addr : wk_reg;
    assign mem_wd = seed_wr.en ? seed_wr.data : tw_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (re_a)
            rd_a <= mem[ra];
        if (re_b)
            rd_b <= mem[rb];
    end

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    mtg_seed_unit u_seed (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_start),
        .seed  (seed_word),
        .wr    (seed_wr),
        .stat  (seed_stat)
    );

    mtg_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (pend_reg && !blocked),
        .word      (rd_a),
        .blocked   (blocked),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "mersenne_twister_generator_core_macros.svh"

    `MTG_ASSERT_NOW(a_no_rw_collide, mem_we && re_a, mem_wa != ra,
        "store write and read hit the same word in one cycle")
    `MTG_ASSERT_NEXT(a_pend_hold, pend_reg && blocked, pend_reg && $stable(rd_a),
        "pending store word lost while output stalled")
    `MTG_ASSERT_NOW(a_seed_only_in_seed, seed_stat.busy, state_reg == ST_SEED,
        "seeder active outside the seeding phase")
    `MTG_ASSERT_NOW(a_gen_after_twist, state_reg == ST_GEN, index_reg == '0,
        "post-twist read not at word zero")

endmodule

`default_nettype wire

/* rtl/mtg_seed_unit.sv */
// Seeding datapath: runs the multiplier recurrence over the whole store.
// Depends on mtg_pkg.
`default_nettype none

module mtg_seed_unit
    import mtg_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [31:0]    seed,
    output mtg_wr_t             wr,
    output mtg_seed_stat_t      stat
);

    logic                 busy_reg, busy_next;
    logic                 phase_reg, phase_next;
    logic [MTG_IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]          prev_reg, prev_next;
    logic [31:0]          prod_reg, prod_next;
    logic [31:0]          word;
    logic                 last;

    assign word = prod_reg + {{(32-MTG_IDX_W){1'b0}}, idx_reg};
    assign last = busy_reg && phase_reg && (idx_reg == MTG_LAST);

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        prod_next  = prod_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            idx_next   = {{(MTG_IDX_W-1){1'b0}}, 1'b1};
            prev_next  = seed;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                // multiply stage, registered before the add
                prod_next  = MTG_SEED_MUL * (prev_reg ^ (prev_reg >> 30));
                phase_next = 1'b1;
            end
            else
            begin
                prev_next  = word;
                phase_next = 1'b0;
                if (last)
                    busy_next = 1'b0;
                else
                    idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        prod_reg <= prod_next;
    end

    assign wr.en   = start || (busy_reg && phase_reg);
    assign wr.addr = start ? '0 : idx_reg;
    assign wr.data = start ? seed : word;

    assign stat.busy = busy_reg;
    assign stat.last = last;

endmodule

`default_nettype wire

/* rtl/mtg_out_stage.sv */
// Output register with tempering of the raw state word.
// Depends on mtg_pkg.
`default_nettype none

module mtg_out_stage
    import mtg_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire logic [31:0]    word,
    output logic                blocked,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [31:0]         value
);

    logic        valid_reg, valid_next;
    logic [31:0] value_reg;
    logic [31:0] t1, t2, t3, t4;

    always_comb
    begin
        t1 = word ^ (word >> 11);
        t2 = t1 ^ ((t1 << 7) & MTG_TEMPER_B);
        t3 = t2 ^ ((t2 << 15) & MTG_TEMPER_C);
        t4 = t3 ^ (t3 >> 18);
    end

    assign blocked = valid_reg && out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (valid_reg && !out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            value_reg <= t4;
    end

    assign out_valid = valid_reg;
    assign value     = value_reg;

endmodule

`default_nettype wire
